// File: rtl/core/stra_pkg.sv
`timescale 1ns / 1ps
package stra_pkg;

  localparam int DEF_LEAVES = 1024;
  localparam int SLOT_W     = 10;
  localparam int VALUE_W    = 21;
  localparam int TAG_W      = 11;
  localparam int RANGE_W    = 11;
  // stored slot index is wide enough for the largest tree
  localparam int SLOT_MAX_W = 16;
  // width used for range and bound comparisons
  localparam int CMP_W      = 18;

  // one tree node: winning slot and its stored value and tag
  typedef struct packed {
    logic                  vld;
    logic [SLOT_MAX_W-1:0] slot;
    logic [VALUE_W-1:0]    value;
    logic [TAG_W-1:0]      tag;
  } key_t;

  localparam int KEY_W = 1 + SLOT_MAX_W + VALUE_W + TAG_W;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic upd_leaf;
    logic upd_rd;
    logic upd_wr;
    logic q_rdl;
    logic q_absl;
    logic q_rdr;
    logic q_absr;
    logic q_shift;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic skip;
    logic upd_top;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic out_free;
  } dp_stat_t;

  // greater value wins, then smaller tag, then higher slot
  function automatic key_t best(input key_t a, input key_t b);
    logic a_wins;
    if (!a.vld) begin
      a_wins = 1'b0;
    end else if (!b.vld) begin
      a_wins = 1'b1;
    end else if (a.value != b.value) begin
      a_wins = $signed(a.value) > $signed(b.value);
    end else if (a.tag != b.tag) begin
      a_wins = $signed(a.tag) < $signed(b.tag);
    end else begin
      a_wins = a.slot > b.slot;
    end
    return a_wins ? a : b;
  endfunction

endpackage

// File: rtl/core/stra_ram.sv
`timescale 1ns / 1ps
module stra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/core/stra_ctrl.sv
`timescale 1ns / 1ps
module stra_ctrl
  import stra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_DISP  = 11'b000_0000_0100,
    S_ULEAF = 11'b000_0000_1000,
    S_URD   = 11'b000_0001_0000,
    S_UWR   = 11'b000_0010_0000,
    S_QL    = 11'b000_0100_0000,
    S_QLW   = 11'b000_1000_0000,
    S_QR    = 11'b001_0000_0000,
    S_QRW   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.skip) state_nxt = S_DONE;
        else if (stat.is_query) state_nxt = S_QL;
        else state_nxt = S_ULEAF;
      end
      S_ULEAF: begin
        cmd.upd_leaf = 1'b1;
        state_nxt    = S_URD;
      end
      S_URD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = stat.upd_top ? S_DONE : S_URD;
      end
      S_QL: begin
        if (!stat.l_lt_r) begin
          state_nxt = S_DONE;
        end else if (stat.l_odd) begin
          cmd.q_rdl = 1'b1;
          state_nxt = S_QLW;
        end else begin
          state_nxt = S_QR;
        end
      end
      S_QLW: begin
        cmd.q_absl = 1'b1;
        state_nxt  = S_QR;
      end
      S_QR: begin
        if (stat.r_odd) begin
          cmd.q_rdr = 1'b1;
          state_nxt = S_QRW;
        end else begin
          cmd.q_shift = 1'b1;
          state_nxt   = S_QL;
        end
      end
      S_QRW: begin
        cmd.q_absr = 1'b1;
        state_nxt  = S_QL;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/stra_dp.sv
`timescale 1ns / 1ps
module stra_dp
  import stra_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic signed [VALUE_W-1:0] in_new_value,
  input  logic signed [TAG_W-1:0]   in_new_tag,
  input  logic [RANGE_W-1:0]        in_range_lo,
  input  logic signed [RANGE_W-1:0] in_range_hi,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [SLOT_W-1:0]         out_win_slot,
  output logic signed [VALUE_W-1:0] out_win_value,
  output logic signed [TAG_W-1:0]   out_win_tag
);

  localparam int IW = $clog2(LEAVES);
  localparam int AW = IW + 1;
  localparam int RW = IW + 2;
  localparam int LW = $clog2(IW + 1);
  localparam int N  = 1 << IW;

  // clear-pass counters
  logic [LW-1:0] lvl_r;
  logic [IW-1:0] pos_r;
  // update walk
  logic [AW-1:0] c_r;
  key_t          cur_r;
  // query walk
  logic [RW-1:0] l_r, r_r;
  key_t          acc_r;
  logic          op_q_r, skip_r;
  // output stage
  logic          out_valid_r, found_r;
  logic [SLOT_W-1:0]  slot_o_r;
  logic [VALUE_W-1:0] value_o_r;
  logic [TAG_W-1:0]   tag_o_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  key_t          wdata, rdata, init_key, merged;

  // initial node contents over the reset slots
  logic [LW-1:0]    shamt;
  logic [IW-1:0]    span_lo, span_hi, pos_mask;
  logic [CMP_W-1:0] lim;

  always_comb begin
    lim      = CMP_W'(LEAVES);
    shamt    = LW'(IW) - lvl_r;
    span_lo  = pos_r << shamt;
    span_hi  = span_lo | ~({IW{1'b1}} << shamt);
    pos_mask = ~({IW{1'b1}} << lvl_r);
    init_key.vld = CMP_W'(span_lo) < lim;
    if (pos_r == '0) begin
      init_key.slot  = '0;
      init_key.value = '0;
    end else begin
      init_key.slot  = (CMP_W'(span_hi) < lim) ? SLOT_MAX_W'(span_hi)
                                               : SLOT_MAX_W'(LEAVES - 1);
      init_key.value = '1;
    end
    init_key.tag = '1;
  end

  // command decode for the item at the ports
  logic [CMP_W-1:0] qa, qb, hs, sl;
  logic             q_empty, u_bad;

  always_comb begin
    qa = CMP_W'(in_range_lo);
    hs = CMP_W'(unsigned'(in_range_hi));
    qb = (hs < lim) ? hs : lim - CMP_W'(1);
    q_empty = in_range_hi[RANGE_W-1] || (qa >= lim) || (qa > qb);
    sl = CMP_W'(in_slot);
    u_bad = sl >= lim;
  end

  assign merged = best(acc_r, rdata);

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = init_key;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = (AW'(1) << lvl_r) | AW'(pos_r);
    end else if (cmd.upd_leaf) begin
      we    = 1'b1;
      waddr = c_r;
      wdata = cur_r;
    end else if (cmd.upd_wr) begin
      we    = 1'b1;
      waddr = c_r >> 1;
      wdata = best(cur_r, rdata);
    end
    raddr = '0;
    if (cmd.upd_rd) raddr = c_r ^ AW'(1);
    else if (cmd.q_rdl) raddr = l_r[AW-1:0];
    else if (cmd.q_rdr) raddr = r_r[AW-1:0] - AW'(1);
  end

  stra_ram #(
    .WIDTH(KEY_W),
    .DEPTH(2 * N)
  ) u_tree (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata_r(rdata)
  );

  // clear-pass sweep, level by level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
      pos_r <= '0;
    end else if (cmd.clr_step) begin
      if (pos_r == pos_mask) begin
        pos_r <= '0;
        lvl_r <= lvl_r + LW'(1);
      end else begin
        pos_r <= pos_r + IW'(1);
      end
    end
  end

  // item registers and tree walks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q_r      <= in_cmd;
      skip_r      <= in_cmd ? q_empty : u_bad;
      acc_r       <= '0;
      c_r         <= AW'(N) | AW'(sl[IW-1:0]);
      cur_r.vld   <= 1'b1;
      cur_r.slot  <= SLOT_MAX_W'(in_slot);
      cur_r.value <= in_new_value;
      cur_r.tag   <= in_new_tag;
      l_r         <= RW'(N) + RW'(qa);
      r_r         <= RW'(N) + RW'(qb) + RW'(1);
    end
    if (cmd.upd_wr) begin
      cur_r <= best(cur_r, rdata);
      c_r   <= c_r >> 1;
    end
    if (cmd.q_absl) begin
      acc_r <= merged;
      l_r   <= l_r + RW'(1);
    end
    if (cmd.q_absr) begin
      acc_r <= merged;
      l_r   <= l_r >> 1;
      r_r   <= r_r >> 1;
    end
    if (cmd.q_shift) begin
      l_r <= l_r >> 1;
      r_r <= r_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_q_r && acc_r.vld) begin
        found_r   <= 1'b1;
        slot_o_r  <= acc_r.slot[SLOT_W-1:0];
        value_o_r <= acc_r.value;
        tag_o_r   <= acc_r.tag;
      end else begin
        found_r   <= 1'b0;
        slot_o_r  <= '0;
        value_o_r <= '0;
        tag_o_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_win_slot  = slot_o_r;
  assign out_win_value = value_o_r;
  assign out_win_tag   = tag_o_r;

  // status
  always_comb begin
    stat.clr_last = (lvl_r == LW'(IW)) && (pos_r == {IW{1'b1}});
    stat.is_query = op_q_r;
    stat.skip     = skip_r;
    stat.upd_top  = (c_r >> 1) == AW'(1);
    stat.l_lt_r   = l_r < r_r;
    stat.l_odd    = l_r[0];
    stat.r_odd    = r_r[0];
    stat.out_free = !out_valid_r || out_ready;
  end

endmodule

// File: rtl/core/segment_tree_range_argmax.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports
// in        input      in_valid/in_ready, in_cmd, in_slot, in_new_value, in_new_tag,
//                      in_range_lo, in_range_hi
// out       output     out_valid/out_ready, out_found, out_win_slot, out_win_value,
//                      out_win_tag
//
// One item at a time. An update reads one sibling and writes one parent per
// level; a query reads the node memory through its single read port, up to two
// reads a level.
// After reset a clearing pass writes all 2*2^ceil(log2(LEAVES))-1 tree nodes,
// one a cycle, before the first item is taken.
// A result waiting in the output register does not block the next item; a
// finished item waits only if the previous result is still untaken.
module segment_tree_range_argmax
  import stra_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic signed [VALUE_W-1:0] in_new_value,
  input  logic signed [TAG_W-1:0]   in_new_tag,
  input  logic [RANGE_W-1:0]        in_range_lo,
  input  logic signed [RANGE_W-1:0] in_range_hi,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [SLOT_W-1:0]         out_win_slot,
  output logic signed [VALUE_W-1:0] out_win_value,
  output logic signed [TAG_W-1:0]   out_win_tag
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stra_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  stra_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (in_cmd),
    .in_slot      (in_slot),
    .in_new_value (in_new_value),
    .in_new_tag   (in_new_tag),
    .in_range_lo  (in_range_lo),
    .in_range_hi  (in_range_hi),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_win_slot (out_win_slot),
    .out_win_value(out_win_value),
    .out_win_tag  (out_win_tag)
  );

  // the clearing pass holds off items right after reset
  a_clr_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  // a result without a winner carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_win_slot == '0 && out_win_value == '0 && out_win_tag == '0))
    else $error("empty result with nonzero fields");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb
  import stra_pkg::*;
();

  localparam int NSLOT = DEF_LEAVES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic signed [VALUE_W-1:0] in_new_value = '0;
  logic signed [TAG_W-1:0] in_new_tag = '0;
  logic [RANGE_W-1:0] in_range_lo = '0;
  logic signed [RANGE_W-1:0] in_range_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [SLOT_W-1:0] out_win_slot;
  logic signed [VALUE_W-1:0] out_win_value;
  logic signed [TAG_W-1:0] out_win_tag;

  // one answer: found flag, slot, value, tag
  typedef struct packed {
    logic found;
    logic [SLOT_W-1:0] slot;
    logic signed [VALUE_W-1:0] value;
    logic signed [TAG_W-1:0] tag;
  } answer_t;

  answer_t answer_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  // shadow of the slot contents
  logic signed [VALUE_W-1:0] shadow_value[NSLOT];
  logic signed [TAG_W-1:0] shadow_tag[NSLOT];

  segment_tree_range_argmax u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // a beats b: greater value, then smaller tag, then higher slot
  function automatic bit wins(int a, int b);
    if (shadow_value[a] != shadow_value[b]) return shadow_value[a] > shadow_value[b];
    if (shadow_tag[a] != shadow_tag[b]) return shadow_tag[a] < shadow_tag[b];
    return a > b;
  endfunction

  // apply one item to the shadow and work out its answer
  function automatic answer_t predict_answer(logic cmd, logic [SLOT_W-1:0] slot,
      logic signed [VALUE_W-1:0] val, logic signed [TAG_W-1:0] tag,
      logic [RANGE_W-1:0] lo, logic signed [RANGE_W-1:0] hi);
    answer_t a;
    int qa;
    int qb;
    int w;
    a = '0;
    if (!cmd) begin
      shadow_value[slot] = val;
      shadow_tag[slot] = tag;
      return a;
    end
    qa = lo;
    qb = hi;
    if (qb < 0 || qa >= NSLOT) return a;
    if (qb > NSLOT - 1) qb = NSLOT - 1;
    if (qa > qb) return a;
    w = qa;
    for (int k = qa + 1; k <= qb; k++) if (wins(k, w)) w = k;
    a.found = 1'b1;
    a.slot = w[SLOT_W-1:0];
    a.value = shadow_value[w];
    a.tag = shadow_tag[w];
    return a;
  endfunction

  // valid stays up after an accept until the next item or an idle cycle
  task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot,
      logic signed [VALUE_W-1:0] val, logic signed [TAG_W-1:0] tag,
      logic [RANGE_W-1:0] lo, logic signed [RANGE_W-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_slot <= slot;
    in_new_value <= val;
    in_new_tag <= tag;
    in_range_lo <= lo;
    in_range_hi <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answer_q.push_back(predict_answer(cmd, slot, val, tag, lo, hi));
  endtask

  task automatic send_update(int slot, int val, int tag);
    send_item(1'b0, SLOT_W'(slot), VALUE_W'(val), TAG_W'(tag),
              RANGE_W'($urandom), RANGE_W'($urandom));
  endtask

  task automatic send_query(int lo, int hi);
    send_item(1'b1, SLOT_W'($urandom), VALUE_W'($urandom), TAG_W'($urandom),
              RANGE_W'(lo), RANGE_W'(hi));
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (!rst_n || recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each taken result against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result found=%0d slot=%0d", $realtime, out_found,
                 out_win_slot);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found exp %0d got %0d", $realtime, want.found, out_found);
          errors++;
        end
        if (out_win_slot !== want.slot) begin
          $display("%0t: win_slot exp %0d got %0d", $realtime, want.slot, out_win_slot);
          errors++;
        end
        if (out_win_value !== want.value) begin
          $display("%0t: win_value exp %0d got %0d", $realtime, want.value, out_win_value);
          errors++;
        end
        if (out_win_tag !== want.tag) begin
          $display("%0t: win_tag exp %0d got %0d", $realtime, want.tag, out_win_tag);
          errors++;
        end
      end
    end
  end

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // random value with the extremes weighted in
  function automatic int rand_value();
    case ($urandom_range(5))
      0: return -1;
      1: return 1048575;
      2: return $urandom_range(3);
      default: return $urandom_range(1048575);
    endcase
  endfunction

  function automatic int rand_tag();
    case ($urandom_range(4))
      0: return -1;
      1: return 1023;
      2: return $urandom_range(3);
      default: return $urandom_range(1023);
    endcase
  endfunction

  // edges, empty ranges, saturation and ties
  task automatic test_directed();
    send_query(0, 1023);
    send_query(0, 2047);
    send_query(5, 1023);
    send_query(3, -1);
    send_query(7, 6);
    send_query(1024, 1023);
    send_query(2047, 1023);
    send_update(1023, 1048575, 1023);
    send_update(0, -1, -1);
    send_query(0, 1023);
    send_update(512, 1048575, -1);
    send_query(0, 1023);
    send_update(511, 1048575, -1);
    send_query(0, 1023);
    send_query(0, 511);
    send_update(100, 7, 3);
    send_update(200, 7, 3);
    send_query(100, 200);
    send_query(100, 100);
    send_query(1023, 1023);
    send_query(1000, -1024);
    drain();
  endtask

  // updates and queries mixed, ranges mostly narrow
  task automatic test_random(int n);
    int lo;
    int hi;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 45) begin
        send_update($urandom_range(1023), rand_value(), rand_tag());
      end else begin
        lo = $urandom_range(1023);
        case ($urandom_range(5))
          0: hi = $urandom_range(2047);
          1: hi = $signed(11'($urandom));
          2: hi = lo - $urandom_range(1, 3);
          default: hi = lo + $urandom_range(40);
        endcase
        if ($urandom_range(30) == 0) lo = 1024 + $urandom_range(1023);
        send_query(lo, hi);
      end
    end
  endtask

  // receiver stops while the sender keeps offering items
  task automatic test_backpressure();
    fork
      test_random(30);
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    for (int k = 0; k < NSLOT; k++) begin
      shadow_value[k] = -1;
      shadow_tag[k] = -1;
    end
    shadow_value[0] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 38;
    recv_idle_pct = 67;
    test_random(220);
    drain();
    send_idle_pct = 67;
    recv_idle_pct = 38;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(220);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stra_pkg.sv
rtl/core/stra_ram.sv
rtl/core/stra_ctrl.sv
rtl/core/stra_dp.sv
rtl/core/segment_tree_range_argmax.sv
sim/tb.sv
